FILE: rtl/rsl_pkg.sv
package rsl_pkg;

  // Field widths.
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned LUM_BITS   = 16;

  // Squared distance. It is at least 15 bits wide so that the near limit fits.
  localparam int unsigned DSQ_BITS = 2 * COORD_BITS;
  localparam int unsigned SQ_BITS  = (DSQ_BITS + 1 > 15) ? DSQ_BITS + 1 : 15;

  // 160 squared. Above it, the far scale applies in every case.
  localparam logic [SQ_BITS-1:0] NEAR_SQ = SQ_BITS'(25600);

  // Integer square root of (sq << 16). The operand fits 32 bits in the near range.
  localparam int unsigned FRAC_SHIFT      = 16;
  localparam int unsigned ROOT_IN_BITS    = 32;
  localparam int unsigned ROOT_BITS       = ROOT_IN_BITS / 2;
  localparam int unsigned ITERS_PER_STAGE = 2;
  localparam int unsigned ROOT_STAGES     = ROOT_BITS / ITERS_PER_STAGE;

  // ceil(dist * 128 / 100) = floor((dist * 32 + 24) / 25), done by a reciprocal.
  localparam int unsigned NUM_BITS    = ROOT_BITS + 5;
  localparam int unsigned RECIP_BITS  = 22;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned PROD_BITS   = NUM_BITS + RECIP_BITS;
  localparam logic [NUM_BITS-1:0]   CEIL_BIAS = NUM_BITS'(24);
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(2684355);

  // Scale factor in units of 2^-16; unity needs the 17th bit.
  localparam int unsigned SCALE_BITS = 17;
  localparam logic [SCALE_BITS-1:0] UNITY_SCALE = SCALE_BITS'(65536);
  localparam logic [SCALE_BITS-1:0] FAR_SCALE   = SCALE_BITS'(13107);
  localparam int unsigned LPROD_BITS = LUM_BITS + SCALE_BITS;

  // Configuration port.
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned REG_IDX_BIT   = 2;
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  // One beat inside the square root pipeline.
  typedef struct packed {
    logic                    far;
    logic [LUM_BITS-1:0]     lum;
    logic [ROOT_IN_BITS-1:0] rem;
    logic [ROOT_IN_BITS-1:0] res;
  } root_beat_t;

  // One beat leaving the square root pipeline.
  typedef struct packed {
    logic                 far;
    logic [LUM_BITS-1:0]  lum;
    logic [ROOT_BITS-1:0] radius;
  } dist_beat_t;

endpackage

FILE: rtl/rsl_cfg.sv
module rsl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsl_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [rsl_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [rsl_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output logic [rsl_pkg::COORD_BITS-1:0]      center_x_o,
  output logic [rsl_pkg::COORD_BITS-1:0]      center_y_o
);
  import rsl_pkg::*;

  logic [COORD_BITS-1:0] center_x_q, center_x_d;
  logic [COORD_BITS-1:0] center_y_q, center_y_d;
  logic                  wr_en;
  logic                  reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[REG_IDX_BIT];
  assign pready  = 1'b1;

  always_comb begin
    center_x_d = center_x_q;
    center_y_d = center_y_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x_d = pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: center_y_d = pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = APB_DATA_BITS'(center_x_q);
      REG_CENTER_Y: prdata = APB_DATA_BITS'(center_y_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else begin
      center_x_q <= center_x_d;
      center_y_q <= center_y_d;
    end
  end

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;

endmodule

FILE: rtl/rsl_dist.sv
module rsl_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rsl_pkg::COORD_BITS-1:0] pixel_x_i,
  input  logic [rsl_pkg::COORD_BITS-1:0] pixel_y_i,
  input  logic [rsl_pkg::LUM_BITS-1:0]   lum_i,
  input  logic [rsl_pkg::COORD_BITS-1:0] center_x_i,
  input  logic [rsl_pkg::COORD_BITS-1:0] center_y_i,
  output logic                           valid_o,
  output rsl_pkg::root_beat_t            beat_o
);
  import rsl_pkg::*;

  // Stage 1: absolute differences.
  logic                  v1_q;
  logic [COORD_BITS-1:0] dx_q, dx_d;
  logic [COORD_BITS-1:0] dy_q, dy_d;
  logic [LUM_BITS-1:0]   lum1_q;
  // Stage 2: squares.
  logic                  v2_q;
  logic [DSQ_BITS-1:0]   dx2_q, dy2_q;
  logic [LUM_BITS-1:0]   lum2_q;
  // Stage 3: sum, near test and root operand.
  logic                  v3_q;
  logic [SQ_BITS-1:0]    sq;
  logic                  far;
  root_beat_t            beat_q, beat_d;

  assign dx_d = (center_x_i >= pixel_x_i) ? center_x_i - pixel_x_i : pixel_x_i - center_x_i;
  assign dy_d = (center_y_i >= pixel_y_i) ? center_y_i - pixel_y_i : pixel_y_i - center_y_i;

  assign sq  = SQ_BITS'(dx2_q) + SQ_BITS'(dy2_q);
  assign far = sq > NEAR_SQ;

  always_comb begin
    beat_d.far = far;
    beat_d.lum = lum2_q;
    beat_d.res = '0;
    // A far pixel gets the constant scale, so its root is never used.
    beat_d.rem = far ? '0 : (ROOT_IN_BITS'(sq) << FRAC_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      lum1_q <= lum_i;
      dx2_q  <= DSQ_BITS'(dx_q) * DSQ_BITS'(dx_q);
      dy2_q  <= DSQ_BITS'(dy_q) * DSQ_BITS'(dy_q);
      lum2_q <= lum1_q;
      beat_q <= beat_d;
    end
  end

  assign valid_o = v3_q;
  assign beat_o  = beat_q;

endmodule

FILE: rtl/rsl_sqrt.sv
module rsl_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rsl_pkg::root_beat_t beat_i,
  output logic                valid_o,
  output rsl_pkg::dist_beat_t beat_o
);
  import rsl_pkg::*;

  // One step of the bitwise restoring square root; iteration it tests bit 2*(15-it).
  function automatic root_beat_t root_step(input root_beat_t b, input int unsigned it);
    logic [ROOT_IN_BITS-1:0] bit_v;
    logic [ROOT_IN_BITS-1:0] trial;
    root_beat_t              r;
    bit_v = ROOT_IN_BITS'(1) << (ROOT_IN_BITS - 2 - 2 * it);
    trial = b.res + bit_v;
    r     = b;
    if (b.rem >= trial) begin
      r.rem = b.rem - trial;
      r.res = (b.res >> 1) + bit_v;
    end else begin
      r.res = b.res >> 1;
    end
    return r;
  endfunction

  root_beat_t             stage_in [ROOT_STAGES];
  root_beat_t             stage_d  [ROOT_STAGES];
  root_beat_t             stage_q  [ROOT_STAGES];
  logic [ROOT_STAGES-1:0] valid_in;
  logic [ROOT_STAGES-1:0] valid_q;

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign stage_in[k] = beat_i;
      assign valid_in[k] = valid_i;
    end else begin : g_next
      assign stage_in[k] = stage_q[k-1];
      assign valid_in[k] = valid_q[k-1];
    end

    assign stage_d[k] = root_step(root_step(stage_in[k], ITERS_PER_STAGE * k),
                                  ITERS_PER_STAGE * k + 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign valid_o       = valid_q[ROOT_STAGES-1];
  assign beat_o.far    = stage_q[ROOT_STAGES-1].far;
  assign beat_o.lum    = stage_q[ROOT_STAGES-1].lum;
  assign beat_o.radius = stage_q[ROOT_STAGES-1].res[ROOT_BITS-1:0];

endmodule

FILE: rtl/rsl_scale.sv
module rsl_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rsl_pkg::dist_beat_t          beat_i,
  output logic                         valid_o,
  output logic [rsl_pkg::LUM_BITS-1:0] lum_o
);
  import rsl_pkg::*;

  // Stage A: reciprocal product for the ceiling of dist * 1.28.
  logic                   va_q;
  logic                   far_a_q;
  logic [LUM_BITS-1:0]    lum_a_q;
  logic [NUM_BITS-1:0]    num;
  logic [PROD_BITS-1:0]   prod_q;
  // Stage B: scale factor.
  logic                   vb_q;
  logic [LUM_BITS-1:0]    lum_b_q;
  logic [ROOT_BITS-1:0]   step_down;
  logic [SCALE_BITS-1:0]  scale_q, scale_d;
  // Stage C: scaled luminance, which is also the output register.
  logic                   vc_q;
  logic [LPROD_BITS-1:0]  lprod;
  logic [LUM_BITS-1:0]    lum_c_q;

  assign num = {beat_i.radius, 5'd0} + CEIL_BIAS;

  assign step_down = prod_q[RECIP_SHIFT +: ROOT_BITS];
  assign scale_d   = far_a_q ? FAR_SCALE : UNITY_SCALE - SCALE_BITS'(step_down);

  assign lprod = LPROD_BITS'(lum_b_q) * LPROD_BITS'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      far_a_q <= beat_i.far;
      lum_a_q <= beat_i.lum;
      prod_q  <= PROD_BITS'(num) * PROD_BITS'(RECIP_MUL);
      lum_b_q <= lum_a_q;
      scale_q <= scale_d;
      lum_c_q <= lprod[FRAC_SHIFT +: LUM_BITS];
    end
  end

  assign valid_o = vc_q;
  assign lum_o   = lum_c_q;

endmodule

FILE: rtl/radial_spotlight_luminance.sv
// Radial spotlight: attenuates pixel luminance with distance from a set center.
// An accepted input beat passes the distance stages, the square root (two root
// bits per stage) and the scaling stages to its output beat. Throughput is one
// pixel per cycle; the whole pipeline holds while out_stall_i stalls a waiting
// output beat. Reset clears all valid bits and both centers.
module radial_spotlight_luminance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_x_i,
  input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_y_i,
  input  logic [rsl_pkg::LUM_BITS-1:0]      lum_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsl_pkg::LUM_BITS-1:0]      lum_out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsl_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rsl_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rsl_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import rsl_pkg::*;

  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic                  pipe_en;
  logic                  dist_valid;
  root_beat_t            root_beat;
  logic                  root_valid;
  dist_beat_t            dist_beat;

  // Every stage moves unless a finished beat is waiting on a stalled output.
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  rsl_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .center_x_o (center_x),
    .center_y_o (center_y)
  );

  rsl_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (in_valid_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .lum_i      (lum_in_i),
    .center_x_i (center_x),
    .center_y_i (center_y),
    .valid_o    (dist_valid),
    .beat_o     (root_beat)
  );

  rsl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (dist_valid),
    .beat_i  (root_beat),
    .valid_o (root_valid),
    .beat_o  (dist_beat)
  );

  rsl_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (root_valid),
    .beat_i  (dist_beat),
    .valid_o (out_valid_o),
    .lum_o   (lum_out_o)
  );

endmodule

FILE: dv/radial_spotlight_luminance_tb.sv
`timescale 1ns / 100ps

module radial_spotlight_luminance_tb;

  typedef logic [rsl_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [rsl_pkg::LUM_BITS-1:0]   lum_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    lum_t   lum;
    logic   typed;
    lum_t   want;
  } pixel_row_t;

  localparam int PIPE_CYCLES = 14;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_PIXELS = 240;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned NEAR_LIMIT_Q8 = 160 * 256;
  localparam longint unsigned UNITY_GAIN = 65536;
  localparam longint unsigned FAR_GAIN = 13107;
  localparam lum_t FULL = '1;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  coord_t pixel_x_i;
  coord_t pixel_y_i;
  lum_t   lum_in_i;
  logic   out_valid_o;
  logic   out_stall_i;
  lum_t   lum_out_o;
  logic   psel;
  logic   penable;
  logic   pwrite;
  logic [rsl_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [rsl_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [rsl_pkg::APB_DATA_BITS-1:0] prdata;
  logic   pready;

  radial_spotlight_luminance dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .lum_in_i   (lum_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .lum_out_o  (lum_out_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Spotlight center as the block should hold it.
  coord_t spot_x;
  coord_t spot_y;
  lum_t   lum_expected[$];
  lum_t   want;
  int     mismatches;
  bit     calm;
  bit     hold_req;

  // Reset centers are both zero. Rows with a typed value are the obvious ones.
  pixel_row_t directed_rows[20] = '{
    '{12'd0,    12'd0,    FULL,      1'b1, FULL},
    '{12'd0,    12'd0,    16'd0,     1'b1, 16'd0},
    '{12'd0,    12'd0,    16'd1,     1'b1, 16'd1},
    '{12'd4095, 12'd4095, FULL,      1'b1, 16'd13106},
    '{12'd4095, 12'd4095, 16'd0,     1'b1, 16'd0},
    '{12'd160,  12'd0,    FULL,      1'b1, 16'd13106},
    '{12'd0,    12'd160,  FULL,      1'b1, 16'd13106},
    '{12'd96,   12'd128,  FULL,      1'b1, 16'd13106},
    '{12'd161,  12'd0,    FULL,      1'b1, 16'd13106},
    '{12'd4095, 12'd0,    FULL,      1'b1, 16'd13106},
    '{12'd159,  12'd0,    FULL,      1'b0, 16'd0},
    '{12'd1,    12'd0,    FULL,      1'b0, 16'd0},
    '{12'd0,    12'd1,    16'h8000,  1'b0, 16'd0},
    '{12'd0,    12'd4095, 16'hAAAA,  1'b0, 16'd0},
    '{12'hAAA,  12'h555,  16'h5555,  1'b0, 16'd0},
    '{12'h555,  12'hAAA,  16'hAAAA,  1'b0, 16'd0},
    '{12'd100,  12'd100,  FULL,      1'b0, 16'd0},
    '{12'd113,  12'd113,  FULL,      1'b0, 16'd0},
    '{12'd114,  12'd113,  16'h7FFF,  1'b0, 16'd0},
    '{12'd3,    12'd4,    FULL,      1'b0, 16'd0}
  };

  function automatic lum_t attenuate(coord_t px, coord_t py, lum_t lum);
    longint unsigned dx, dy, radicand, root, trial, gain;
    dx = (px >= spot_x) ? px - spot_x : spot_x - px;
    dy = (py >= spot_y) ? py - spot_y : spot_y - py;
    radicand = (dx * dx + dy * dy) << 16;
    // Build the floor root one bit at a time from the top; it stays below 2^22.
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    if (root <= NEAR_LIMIT_Q8) gain = UNITY_GAIN - (root * 128 + 99) / 100;
    else gain = FAR_GAIN;
    return lum_t'((lum * gain) >> 16);
  endfunction

  function automatic coord_t nudge(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 340)) - 170;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  // Offers one pixel beat and records its expected luminance once it is taken.
  task automatic send_pixel(input coord_t px, input coord_t py, input lum_t lum,
                            input lum_t lum_want);
    bit taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    lum_in_i <= lum;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) lum_expected.push_back(lum_want);
      @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lum_expected.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES + 6) @(posedge clk_i);
  endtask

  // Upper data bits carry junk; only the low coordinate bits should land.
  task automatic write_center(input logic reg_idx, input coord_t value);
    logic [rsl_pkg::APB_DATA_BITS-1:0] data;
    bit done;
    data = $urandom();
    data[rsl_pkg::COORD_BITS-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == rsl_pkg::REG_CENTER_X) spot_x = value;
    else spot_y = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lum_expected.size() == 0) begin
        $error("lum_out: no beat expected, actual %0d", lum_out_o);
        mismatches++;
      end else begin
        want = lum_expected.pop_front();
        if (lum_out_o !== want) begin
          $error("lum_out: expected %0d, actual %0d", want, lum_out_o);
          mismatches++;
        end
      end
    end
  end

  // Output side back-pressure, with one long hold when the stimulus asks for it.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  initial begin
    coord_t cx, cy, px, py;
    lum_t lum;
    int unsigned pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_x_i = '0;
    pixel_y_i = '0;
    lum_in_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    spot_x = '0;
    spot_y = '0;
    mismatches = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].lum,
                 directed_rows[i].typed ? directed_rows[i].want :
                 attenuate(directed_rows[i].px, directed_rows[i].py, directed_rows[i].lum));
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin cx = 12'd4095; cy = 12'd4095; end
        1: begin cx = 12'd0;    cy = 12'd4095; end
        2: begin cx = 12'd4095; cy = 12'd0;    end
        3: begin cx = 12'd2048; cy = 12'd2048; end
        7: begin cx = 12'd0;    cy = 12'd0;    end
        default: begin cx = coord_t'($urandom()); cy = coord_t'($urandom()); end
      endcase
      calm = (p == NUM_PHASES - 1);
      write_center(rsl_pkg::REG_CENTER_X, cx);
      write_center(rsl_pkg::REG_CENTER_Y, cy);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (p == 1 && n == 30) hold_req = 1'b1;
        // Let the pipeline run dry once in the middle of a phase.
        if (p == 2 && n == 120) drain();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          px = spot_x;
          py = spot_y;
        end else if (pick <= 5) begin
          px = nudge(spot_x);
          py = nudge(spot_y);
        end else begin
          px = coord_t'($urandom());
          py = coord_t'($urandom());
        end
        case ($urandom_range(0, 7))
          0: lum = FULL;
          1: lum = '0;
          default: lum = lum_t'($urandom());
        endcase
        send_pixel(px, py, lum, attenuate(px, py, lum));
      end
      drain();
    end

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
